// File: rtl/core/rstt_pkg.sv
// Shared types, constants and codes for the RSI signal and trade tracker.
`timescale 1ns / 1ps
package rstt_pkg;

  localparam int PERIOD  = 14;
  localparam int PTR_W   = $clog2(PERIOD);
  localparam int SEEN_W  = $clog2(PERIOD + 2);
  localparam int PRICE_W = 32;
  localparam int DELTA_W = PRICE_W + 1;
  localparam int SUM_W   = 37;
  localparam int TOTAL_W = 48;
  localparam int NUM_W   = 52;
  localparam int DEN_W   = 38;
  localparam int STEP_W  = $clog2(NUM_W + 1);

  localparam logic [2:0] SIG_NONE       = 3'd0;
  localparam logic [2:0] SIG_BUY        = 3'd1;
  localparam logic [2:0] SIG_EXIT_LONG  = 3'd2;
  localparam logic [2:0] SIG_SHORT      = 3'd3;
  localparam logic [2:0] SIG_EXIT_SHORT = 3'd4;

  localparam logic [1:0] REG_UPPER  = 2'd0;
  localparam logic [1:0] REG_LOWER  = 2'd1;
  localparam logic [1:0] REG_MOVE   = 2'd2;
  localparam logic [1:0] REG_PROFIT = 2'd3;

  typedef enum logic [1:0] {
    POS_NONE  = 2'd0,
    POS_LONG  = 2'd1,
    POS_SHORT = 2'd2
  } pos_kind_t;

  typedef struct packed {
    logic [31:0] close_price;
    logic        last;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         signal;
    logic [14:0]        rsi_value;
    logic               evaluated;
    logic               trade_closed;
    logic signed [31:0] trade_return;
    logic [15:0]        trades_total;
    logic [15:0]        trades_won;
    logic [14:0]        success_percent;
    logic signed [31:0] mean_return_percent;
    logic               summary_valid;
  } out_item_t;

  typedef struct packed {
    logic [6:0]         upper_level;
    logic [6:0]         lower_level;
    logic [15:0]        move_threshold;
    logic signed [16:0] win_floor;
  } cfg_t;

  // Item plus its warm-up class, as tagged by the front end.
  typedef struct packed {
    in_item_t item;
    logic     upd;
    logic     rsi_on;
    logic     eval_on;
  } q_item_t;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

endpackage

// File: rtl/core/rstt_front.sv
// Front end: accept items and tag each with its warm-up class.
`timescale 1ns / 1ps
module rstt_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  rstt_pkg::in_item_t        in_data,
  input  logic                      q_full,
  output logic                      q_push,
  output rstt_pkg::q_item_t         q_wdata
);

  logic [rstt_pkg::SEEN_W-1:0] seen_r;
  logic [rstt_pkg::SEEN_W-1:0] seen_nxt;

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_wdata.item    = in_data;
    q_wdata.upd     = (seen_r != '0);
    q_wdata.rsi_on  = (seen_r >= rstt_pkg::SEEN_W'(rstt_pkg::PERIOD));
    q_wdata.eval_on = (seen_r >= rstt_pkg::SEEN_W'(rstt_pkg::PERIOD + 1));
  end

  always_comb begin
    seen_nxt = seen_r;
    if (q_push) begin
      if (in_data.last) begin
        seen_nxt = '0;
      end else if (seen_r < rstt_pkg::SEEN_W'(rstt_pkg::PERIOD + 1)) begin
        seen_nxt = seen_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= '0;
    end else begin
      seen_r <= seen_nxt;
    end
  end

endmodule

// File: rtl/core/rstt_queue.sv
// Two-entry queue between front end and back end.
`timescale 1ns / 1ps
module rstt_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  rstt_pkg::q_item_t wdata,
  input  logic              pop,
  output rstt_pkg::q_item_t rdata,
  output logic              full,
  output logic              empty
);

  rstt_pkg::q_item_t mem_r [2];
  logic              wr_ptr_r;
  logic              rd_ptr_r;
  logic [1:0]        cnt_r;

  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign rdata = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

endmodule

// File: rtl/core/rstt_div.sv
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module rstt_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  rstt_pkg::div_req_t             req,
  output logic                           done,
  output logic [rstt_pkg::NUM_W-1:0]     quo
);

  localparam int NW = rstt_pkg::NUM_W;
  localparam int DW = rstt_pkg::DEN_W;

  logic                      busy_r;
  logic                      done_r;
  logic [rstt_pkg::STEP_W-1:0] step_r;
  logic [DW-1:0]             rem_r;
  logic [DW-1:0]             den_r;
  logic [NW-1:0]             quo_r;
  logic [DW:0]               rem_sh;
  logic [DW:0]               rem_diff;
  logic                      q_bit;

  assign done = done_r;
  assign quo  = quo_r;

  always_comb begin
    rem_sh   = {rem_r, quo_r[NW-1]};
    rem_diff = rem_sh - {1'b0, den_r};
    q_bit    = (rem_sh >= {1'b0, den_r});
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      den_r <= req.den;
      quo_r <= req.num;
      rem_r <= '0;
    end else if (busy_r) begin
      rem_r <= q_bit ? rem_diff[DW-1:0] : rem_sh[DW-1:0];
      quo_r <= {quo_r[NW-2:0], q_bit};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 1'b1;
        if (step_r == rstt_pkg::STEP_W'(NW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

// File: rtl/core/rstt_back.sv
// Back end: RSI sums, signal machine, trade booking and result register.
`timescale 1ns / 1ps
module rstt_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  rstt_pkg::cfg_t       cfg,
  input  logic                 q_empty,
  input  rstt_pkg::q_item_t    q_rdata,
  output logic                 q_pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output rstt_pkg::out_item_t  out_data
);

  localparam int DW  = rstt_pkg::DELTA_W;
  localparam int SW  = rstt_pkg::SUM_W;
  localparam int TW  = rstt_pkg::TOTAL_W;
  localparam int NW  = rstt_pkg::NUM_W;
  localparam int DNW = rstt_pkg::DEN_W;

  typedef enum logic [11:0] {
    S_IDLE = 12'b0000_0000_0001,
    S_UPD  = 12'b0000_0000_0010,
    S_MUL  = 12'b0000_0000_0100,
    S_CMP  = 12'b0000_0000_1000,
    S_RSI  = 12'b0000_0001_0000,
    S_SIG  = 12'b0000_0010_0000,
    S_RET  = 12'b0000_0100_0000,
    S_BOOK = 12'b0000_1000_0000,
    S_SUMM = 12'b0001_0000_0000,
    S_MEAN = 12'b0010_0000_0000,
    S_OUT  = 12'b0100_0000_0000,
    S_WAIT = 12'b1000_0000_0000
  } st_t;

  typedef enum logic [3:0] {
    DU_RSI  = 4'b0001,
    DU_RET  = 4'b0010,
    DU_SUCC = 4'b0100,
    DU_MEAN = 4'b1000
  } div_use_t;

  function automatic logic [DW-1:0] mag33(input logic [DW-1:0] v);
    mag33 = v[DW-1] ? (~v + 1'b1) : v;
  endfunction

  function automatic logic signed [31:0] sat_q(input logic neg, input logic [NW-1:0] q);
    if (neg) begin
      sat_q = (q > NW'(64'h8000_0000)) ? 32'sh8000_0000 : 32'(-q);
    end else begin
      sat_q = (q > NW'(64'h7FFF_FFFF)) ? 32'sh7FFF_FFFF : 32'(q);
    end
  endfunction

  st_t                        st_r;
  st_t                        after_r;
  div_use_t                   use_r;
  rstt_pkg::q_item_t          itm_r;

  logic signed [DW-1:0]       ring_r [rstt_pkg::PERIOD];
  logic [rstt_pkg::PTR_W-1:0] ptr_r;
  logic [SW-1:0]              gain_r;
  logic [SW-1:0]              loss_r;
  logic [31:0]                prev_r;
  logic                       rise_r;
  logic                       fall_r;
  rstt_pkg::pos_kind_t        pos_r;
  logic [31:0]                entry_r;
  logic signed [TW-1:0]       total_r;
  logic [15:0]                trades_r;
  logic [15:0]                wins_r;

  logic signed [DW-1:0]       d_r;
  logic [DNW-1:0]             sum_r;
  logic [NW-1:0]              p_rsi_r;
  logic [44:0]                p_g100_r;
  logic [44:0]                p_up_r;
  logic [44:0]                p_lo_r;
  logic [47:0]                rhs_r;
  logic                       lhs_gt_r;
  logic                       lhs_lt_r;
  logic                       neg_r;

  logic [2:0]                 sig_r;
  logic [14:0]                rsi_r;
  logic                       closed_r;
  logic signed [31:0]         ret_r;
  logic [14:0]                succ_r;
  logic signed [31:0]         mean_r;

  logic                       out_valid_r;
  rstt_pkg::out_item_t        out_data_r;

  logic                       div_done;
  logic [NW-1:0]              div_quo;
  rstt_pkg::div_req_t         div_req;

  // Combinational helpers.
  logic signed [DW-1:0]       d_c;
  logic signed [DW-1:0]       old_c;
  logic [SW-1:0]              gain_nxt;
  logic [SW-1:0]              loss_nxt;
  logic signed [49:0]         lhs_c;
  logic signed [49:0]         rhs_c;
  logic                       loss0;
  logic                       above_up, below_up, above_lo, below_lo;
  logic [2:0]                 sig_c;
  logic                       rise_c, fall_c;
  rstt_pkg::pos_kind_t        pos_c;
  logic                       sig_close;
  logic signed [DW:0]         tdiff_c;
  logic [DW:0]                tmag_c;
  logic [TW-1:0]              tot_mag_c;
  logic [54:0]                tot_prod_c;
  logic signed [TW:0]         tot_sum_c;
  logic signed [TW-1:0]       tot_nxt;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign q_pop     = (st_r == S_IDLE) && !q_empty && !out_valid_r;

  rstt_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_comb begin
    d_c   = $signed({1'b0, itm_r.item.close_price}) - $signed({1'b0, prev_r});
    old_c = ring_r[ptr_r];
    gain_nxt = gain_r;
    loss_nxt = loss_r;
    if (!old_c[DW-1] && old_c != '0) begin
      gain_nxt = gain_nxt - SW'(old_c);
    end else begin
      loss_nxt = loss_nxt - SW'(mag33(old_c));
    end
    if (!d_c[DW-1] && d_c != '0) begin
      gain_nxt = gain_nxt + SW'(d_c);
    end else begin
      loss_nxt = loss_nxt + SW'(mag33(d_c));
    end

    lhs_c = 50'($signed({d_r, 16'h0000}));
    rhs_c = $signed({2'b00, rhs_r});

    loss0    = (loss_r == '0);
    above_up = loss0 ? (7'd100 > cfg.upper_level) : (p_g100_r > p_up_r);
    below_up = loss0 ? (7'd100 < cfg.upper_level) : (p_g100_r < p_up_r);
    above_lo = loss0 ? (7'd100 > cfg.lower_level) : (p_g100_r > p_lo_r);
    below_lo = loss0 ? (7'd100 < cfg.lower_level) : (p_g100_r < p_lo_r);

    sig_c  = rstt_pkg::SIG_NONE;
    rise_c = rise_r;
    fall_c = fall_r;
    if (itm_r.eval_on) begin
      priority if (above_up && lhs_gt_r) begin
        if (!rise_r) sig_c = rstt_pkg::SIG_BUY;
        rise_c = 1'b1;
        fall_c = 1'b0;
      end else if (rise_r && below_up) begin
        sig_c  = rstt_pkg::SIG_EXIT_LONG;
        rise_c = 1'b0;
      end else if (below_lo && lhs_lt_r) begin
        if (!fall_r) sig_c = rstt_pkg::SIG_SHORT;
        fall_c = 1'b1;
        rise_c = 1'b0;
      end else if (fall_r && above_lo) begin
        sig_c  = rstt_pkg::SIG_EXIT_SHORT;
        fall_c = 1'b0;
      end
    end

    pos_c     = pos_r;
    sig_close = 1'b0;
    if (itm_r.eval_on) begin
      if (pos_r == rstt_pkg::POS_NONE) begin
        if (sig_c == rstt_pkg::SIG_BUY) pos_c = rstt_pkg::POS_LONG;
        else if (sig_c == rstt_pkg::SIG_SHORT) pos_c = rstt_pkg::POS_SHORT;
      end else begin
        sig_close = (pos_r == rstt_pkg::POS_LONG && sig_c == rstt_pkg::SIG_EXIT_LONG) ||
                    (pos_r == rstt_pkg::POS_SHORT && sig_c == rstt_pkg::SIG_EXIT_SHORT);
      end
    end

    tdiff_c = $signed({2'b00, itm_r.item.close_price}) - $signed({2'b00, entry_r});
    if (pos_r == rstt_pkg::POS_SHORT) tdiff_c = -tdiff_c;
    tmag_c = tdiff_c[DW] ? (DW+1)'(~tdiff_c + 1'b1) : (DW+1)'(tdiff_c);

    tot_mag_c  = total_r[TW-1] ? TW'(-total_r) : TW'(total_r);
    tot_prod_c = 55'(tot_mag_c) * 55'd100;

    tot_sum_c = (TW+1)'(total_r) + (TW+1)'(ret_r);
    if (tot_sum_c > $signed({2'b00, {(TW-1){1'b1}}})) begin
      tot_nxt = {1'b0, {(TW-1){1'b1}}};
    end else if (tot_sum_c < $signed({2'b11, {(TW-1){1'b0}}})) begin
      tot_nxt = {1'b1, {(TW-1){1'b0}}};
    end else begin
      tot_nxt = TW'(tot_sum_c);
    end

    div_req.start = 1'b0;
    div_req.num   = p_rsi_r;
    div_req.den   = sum_r;
    unique case (st_r)
      S_RSI: begin
        div_req.start = itm_r.rsi_on && !loss0;
      end
      S_RET: begin
        div_req.start = (entry_r != '0);
        div_req.num   = NW'({tmag_c, 16'h0000});
        div_req.den   = DNW'(entry_r);
      end
      S_SUMM: begin
        div_req.start = itm_r.item.last && (trades_r != '0);
        div_req.num   = NW'(32'(wins_r) * 32'd25600);
        div_req.den   = DNW'(trades_r);
      end
      S_MEAN: begin
        div_req.start = 1'b1;
        div_req.num   = NW'(tot_prod_c[54:8]);
        div_req.den   = DNW'(trades_r);
      end
      default: begin
        div_req.start = 1'b0;
      end
    endcase
  end

  // Datapath registers without reset.
  always_ff @(posedge clk) begin
    unique case (st_r)
      S_IDLE: begin
        if (q_pop) itm_r <= q_rdata;
        sig_r    <= rstt_pkg::SIG_NONE;
        ret_r    <= '0;
        succ_r   <= '0;
        mean_r   <= '0;
      end
      S_UPD: begin
        d_r <= d_c;
      end
      S_MUL: begin
        sum_r    <= DNW'(gain_r) + DNW'(loss_r);
        p_rsi_r  <= NW'(gain_r) * NW'(25600);
        p_g100_r <= 45'(gain_r) * 45'd100;
        rhs_r    <= 48'(cfg.move_threshold) * 48'(prev_r);
      end
      S_CMP: begin
        p_up_r   <= 45'(cfg.upper_level) * 45'(sum_r);
        p_lo_r   <= 45'(cfg.lower_level) * 45'(sum_r);
        lhs_gt_r <= lhs_c > rhs_c;
        lhs_lt_r <= lhs_c < -rhs_c;
      end
      S_RSI: begin
        rsi_r <= itm_r.rsi_on ? 15'd25600 : 15'd12800;
      end
      S_SIG: begin
        sig_r <= sig_c;
      end
      S_RET: begin
        neg_r <= tdiff_c[DW];
      end
      S_MEAN: begin
        neg_r <= total_r[TW-1];
      end
      S_WAIT: begin
        if (div_done) begin
          unique case (use_r)
            DU_RSI:  rsi_r  <= 15'(div_quo);
            DU_RET:  ret_r  <= sat_q(neg_r, div_quo);
            DU_SUCC: succ_r <= 15'(div_quo);
            DU_MEAN: mean_r <= sat_q(neg_r, div_quo);
            default: rsi_r  <= rsi_r;
          endcase
        end
      end
      default: begin
      end
    endcase
    if (st_r == S_OUT && !out_valid_r) begin
      out_data_r.signal              <= sig_r;
      out_data_r.rsi_value           <= rsi_r;
      out_data_r.evaluated           <= itm_r.eval_on;
      out_data_r.trade_closed        <= closed_r;
      out_data_r.trade_return        <= ret_r;
      out_data_r.trades_total        <= trades_r;
      out_data_r.trades_won          <= wins_r;
      out_data_r.success_percent     <= succ_r;
      out_data_r.mean_return_percent <= mean_r;
      out_data_r.summary_valid       <= itm_r.item.last;
    end
  end

  // Control and model state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      after_r     <= S_IDLE;
      use_r       <= DU_RSI;
      out_valid_r <= 1'b0;
      for (int i = 0; i < rstt_pkg::PERIOD; i++) ring_r[i] <= '0;
      ptr_r    <= '0;
      gain_r   <= '0;
      loss_r   <= '0;
      prev_r   <= '0;
      rise_r   <= 1'b0;
      fall_r   <= 1'b0;
      pos_r    <= rstt_pkg::POS_NONE;
      entry_r  <= '0;
      total_r  <= '0;
      trades_r <= '0;
      wins_r   <= '0;
      closed_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      unique case (st_r)
        S_IDLE: begin
          closed_r <= 1'b0;
          if (q_pop) st_r <= S_UPD;
        end
        S_UPD: begin
          if (itm_r.upd) begin
            ring_r[ptr_r] <= d_c;
            gain_r <= gain_nxt;
            loss_r <= loss_nxt;
            ptr_r  <= (ptr_r == rstt_pkg::PTR_W'(rstt_pkg::PERIOD - 1)) ? '0 : ptr_r + 1'b1;
          end
          st_r <= S_MUL;
        end
        S_MUL: st_r <= S_CMP;
        S_CMP: st_r <= S_RSI;
        S_RSI: begin
          if (div_req.start) begin
            use_r   <= DU_RSI;
            after_r <= S_SIG;
            st_r    <= S_WAIT;
          end else begin
            st_r <= S_SIG;
          end
        end
        S_SIG: begin
          rise_r <= rise_c;
          fall_r <= fall_c;
          pos_r  <= pos_c;
          if (pos_r == rstt_pkg::POS_NONE && pos_c != rstt_pkg::POS_NONE) begin
            entry_r <= itm_r.item.close_price;
          end
          // Close on a matching exit, or force-close on the final item.
          if (sig_close || (itm_r.item.last && pos_c != rstt_pkg::POS_NONE)) begin
            st_r <= S_RET;
          end else begin
            st_r <= S_SUMM;
          end
        end
        S_RET: begin
          if (div_req.start) begin
            use_r   <= DU_RET;
            after_r <= S_BOOK;
            st_r    <= S_WAIT;
          end else begin
            st_r <= S_BOOK;
          end
        end
        S_BOOK: begin
          total_r  <= tot_nxt;
          if (ret_r > 32'(cfg.win_floor) && wins_r != 16'hFFFF) wins_r <= wins_r + 1'b1;
          if (trades_r != 16'hFFFF) trades_r <= trades_r + 1'b1;
          pos_r    <= rstt_pkg::POS_NONE;
          closed_r <= 1'b1;
          st_r     <= S_SUMM;
        end
        S_SUMM: begin
          if (div_req.start) begin
            use_r   <= DU_SUCC;
            after_r <= S_MEAN;
            st_r    <= S_WAIT;
          end else begin
            st_r <= S_OUT;
          end
        end
        S_MEAN: begin
          use_r   <= DU_MEAN;
          after_r <= S_OUT;
          st_r    <= S_WAIT;
        end
        S_WAIT: begin
          if (div_done) st_r <= after_r;
        end
        S_OUT: begin
          if (!out_valid_r) begin
            out_valid_r <= 1'b1;
            prev_r      <= itm_r.item.last ? 32'd0 : itm_r.item.close_price;
            st_r        <= S_IDLE;
            if (itm_r.item.last) begin
              // Drop all series state after the final item.
              for (int i = 0; i < rstt_pkg::PERIOD; i++) ring_r[i] <= '0;
              ptr_r    <= '0;
              gain_r   <= '0;
              loss_r   <= '0;
              rise_r   <= 1'b0;
              fall_r   <= 1'b0;
              pos_r    <= rstt_pkg::POS_NONE;
              entry_r  <= '0;
              total_r  <= '0;
              trades_r <= '0;
              wins_r   <= '0;
            end
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/core/rsi_signal_trade_tracker.sv
// Top level of the RSI signal and trade tracker.
`timescale 1ns / 1ps
// One closing price (unsigned Q16.16) goes in per item and one result comes
// out per item, in order. A two-entry queue sits between the input side and
// the sequencer, so up to two items are taken while a result waits. The
// sequencer works on one item at a time, and each division runs in the
// shared one-bit-per-cycle divider. Items past warm-up with losses in the
// window need one division (RSI); a closing trade adds the return and
// booking states and one division when its entry price is not zero; the final
// item of a series with closed trades adds the mean state and two more
// divisions for the success rate and mean return.
// Configuration is written through cfg_we/cfg_index/cfg_wdata while idle.
module rsi_signal_trade_tracker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  rstt_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output rstt_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [16:0]         cfg_wdata
);

  rstt_pkg::cfg_t    cfg_r;
  logic              q_push;
  logic              q_pop;
  logic              q_full;
  logic              q_empty;
  rstt_pkg::q_item_t q_wdata;
  rstt_pkg::q_item_t q_rdata;

  // Hold the configuration registers; the user is to write them only while idle, which the block does not enforce.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.upper_level    <= 7'd60;
      cfg_r.lower_level    <= 7'd40;
      cfg_r.move_threshold <= 16'd3277;
      cfg_r.win_floor      <= 17'sd328;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rstt_pkg::REG_UPPER:  cfg_r.upper_level    <= cfg_wdata[6:0];
        rstt_pkg::REG_LOWER:  cfg_r.lower_level    <= cfg_wdata[6:0];
        rstt_pkg::REG_MOVE:   cfg_r.move_threshold <= cfg_wdata[15:0];
        rstt_pkg::REG_PROFIT: cfg_r.win_floor      <= $signed(cfg_wdata);
        default:              cfg_r <= cfg_r;
      endcase
    end
  end

  // Tag items by warm-up position.
  rstt_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_wdata  (q_wdata)
  );

  rstt_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  // Run RSI, signals and trade booking; drive the result register.
  rstt_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_empty   (q_empty),
    .q_rdata   (q_rdata),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// File: tb/tb_rsi_signal_trade_tracker.sv
// Testbench for the RSI signal and trade tracker: directed and random series against a predictor.
`timescale 1ns / 1ps
module tb_rsi_signal_trade_tracker;
  import rstt_pkg::*;

  localparam int CYCLE_LIMIT = 2000000;
  localparam int TAIL_CYCLES = 300;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = REG_UPPER;
  logic [16:0] cfg_wdata = '0;

  always #2 clk = ~clk;

  rsi_signal_trade_tracker u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // Stimulus and expected results.
  in_item_t price_queue[$];
  out_item_t expected_results[$];
  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_off_cycles = 0;
  int mismatches = 0;
  int results_seen = 0;
  int trades_seen = 0;
  int summaries_seen = 0;
  longint cycle_count = 0;

  // Predictor copy of the block: configuration and state.
  logic [6:0] upper_q = 7'd60;
  logic [6:0] lower_q = 7'd40;
  logic [15:0] move_q = 16'd3277;
  longint profit_q = 328;
  longint delta_hist[PERIOD];
  int hist_ptr;
  longint gains, losses, prev_close;
  int seen_cnt;
  bit rise_arm, fall_arm;
  pos_kind_t holding;
  longint entry_px, ret_total;
  int n_trades, n_wins;

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic void wipe_series();
    foreach (delta_hist[i]) delta_hist[i] = 0;
    hist_ptr = 0; gains = 0; losses = 0; prev_close = 0; seen_cnt = 0;
    rise_arm = 0; fall_arm = 0; holding = POS_NONE; entry_px = 0;
    ret_total = 0; n_trades = 0; n_wins = 0;
  endfunction

  function automatic bit rsi_over(longint lvl);
    if (losses == 0) return 100 > lvl;
    return 100 * gains > lvl * (gains + losses);
  endfunction

  function automatic bit rsi_under(longint lvl);
    if (losses == 0) return 100 < lvl;
    return 100 * gains < lvl * (gains + losses);
  endfunction

  function automatic longint trade_gain(longint exit_px);
    longint diff;
    if (entry_px == 0) return 0;
    diff = exit_px - entry_px;
    if (holding == POS_SHORT) diff = -diff;
    return clamp32((diff * 65536) / entry_px);
  endfunction

  function automatic void close_trade(longint r);
    longint tmax;
    tmax = 64'sd140737488355327;
    ret_total += r;
    if (ret_total > tmax) ret_total = tmax;
    if (ret_total < -tmax - 1) ret_total = -tmax - 1;
    if (r > profit_q && n_wins < 65535) n_wins++;
    if (n_trades < 65535) n_trades++;
    holding = POS_NONE;
  endfunction

  // Advance the predictor by one price and return the result it implies.
  function automatic out_item_t predict_bar(in_item_t it);
    out_item_t r;
    longint cl, d, old, lhs, rhs, ret, mean;
    logic [2:0] sig;
    bit closed;
    int idx;
    cl = longint'(it.close_price);
    idx = seen_cnt;
    sig = SIG_NONE; closed = 0; ret = 0; mean = 0;
    r = '0;
    r.rsi_value = 15'd12800;
    if (idx > 0) begin
      d = cl - prev_close;
      old = delta_hist[hist_ptr];
      if (old > 0) gains -= old; else losses += old;
      if (d > 0) gains += d; else losses -= d;
      delta_hist[hist_ptr] = d;
      hist_ptr = (hist_ptr + 1 >= PERIOD) ? 0 : hist_ptr + 1;
    end
    if (idx >= PERIOD)
      r.rsi_value = (losses == 0) ? 15'd25600 : 15'((25600 * gains) / (gains + losses));
    if (idx >= PERIOD + 1) begin
      lhs = (cl - prev_close) * 65536;
      rhs = longint'(move_q) * prev_close;
      r.evaluated = 1'b1;
      if (rsi_over(upper_q) && lhs > rhs) begin
        if (!rise_arm) begin
          sig = SIG_BUY; rise_arm = 1;
        end
        fall_arm = 0;
      end else if (rise_arm && rsi_under(upper_q)) begin
        sig = SIG_EXIT_LONG; rise_arm = 0;
      end else if (rsi_under(lower_q) && lhs < -rhs) begin
        if (!fall_arm) begin
          sig = SIG_SHORT; fall_arm = 1;
        end
        rise_arm = 0;
      end else if (fall_arm && rsi_over(lower_q)) begin
        sig = SIG_EXIT_SHORT; fall_arm = 0;
      end
      if (holding == POS_NONE) begin
        if (sig == SIG_BUY) begin
          holding = POS_LONG; entry_px = cl;
        end else if (sig == SIG_SHORT) begin
          holding = POS_SHORT; entry_px = cl;
        end
      end else if ((holding == POS_LONG && sig == SIG_EXIT_LONG) ||
                   (holding == POS_SHORT && sig == SIG_EXIT_SHORT)) begin
        ret = trade_gain(cl); close_trade(ret); closed = 1;
      end
    end
    if (it.last && holding != POS_NONE) begin
      ret = trade_gain(cl); close_trade(ret); closed = 1;
    end
    if (it.last && n_trades > 0) begin
      r.success_percent = 15'((longint'(n_wins) * 25600) / n_trades);
      mean = clamp32((ret_total * 100) / (longint'(n_trades) * 256));
    end
    r.signal = sig;
    r.trade_closed = closed;
    r.trade_return = 32'(ret);
    r.trades_total = 16'(n_trades);
    r.trades_won = 16'(n_wins);
    r.mean_return_percent = 32'(mean);
    r.summary_valid = it.last;
    prev_close = cl;
    seen_cnt = (idx + 1 > PERIOD + 1) ? PERIOD + 1 : idx + 1;
    if (it.last) wipe_series();
    return r;
  endfunction

  // Driver: offer the head of the price queue, hold it while stalled.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (price_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_data <= price_queue.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Predict at acceptance so the expectation order matches the item order.
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall)
      expected_results.insert(expected_results.size(), predict_bar(in_data));
  end

  // Receiver stall: a long hold-off wins over the random pattern.
  always @(posedge clk) begin
    if (hold_off_cycles > 0) begin
      out_stall <= 1'b1;
      hold_off_cycles <= hold_off_cycles - 1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Monitor: compare each accepted result field by field with the oldest expectation.
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        $error("result with no expectation waiting: %p", out_data);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        if (out_data.trade_closed) trades_seen++;
        if (out_data.summary_valid) summaries_seen++;
        if (out_data.signal !== want.signal) begin
          $error("signal: expected %0d, got %0d", want.signal, out_data.signal);
          mismatches++;
        end
        if (out_data.rsi_value !== want.rsi_value) begin
          $error("rsi_value: expected %0d, got %0d", want.rsi_value, out_data.rsi_value);
          mismatches++;
        end
        if (out_data.evaluated !== want.evaluated) begin
          $error("evaluated: expected %0d, got %0d", want.evaluated, out_data.evaluated);
          mismatches++;
        end
        if (out_data.trade_closed !== want.trade_closed) begin
          $error("trade_closed: expected %0d, got %0d", want.trade_closed,
                 out_data.trade_closed);
          mismatches++;
        end
        if (out_data.trade_return !== want.trade_return) begin
          $error("trade_return: expected %0d, got %0d", want.trade_return,
                 out_data.trade_return);
          mismatches++;
        end
        if (out_data.trades_total !== want.trades_total) begin
          $error("trades_total: expected %0d, got %0d", want.trades_total,
                 out_data.trades_total);
          mismatches++;
        end
        if (out_data.trades_won !== want.trades_won) begin
          $error("trades_won: expected %0d, got %0d", want.trades_won, out_data.trades_won);
          mismatches++;
        end
        if (out_data.success_percent !== want.success_percent) begin
          $error("success_percent: expected %0d, got %0d", want.success_percent,
                 out_data.success_percent);
          mismatches++;
        end
        if (out_data.mean_return_percent !== want.mean_return_percent) begin
          $error("mean_return_percent: expected %0d, got %0d", want.mean_return_percent,
                 out_data.mean_return_percent);
          mismatches++;
        end
        if (out_data.summary_valid !== want.summary_valid) begin
          $error("summary_valid: expected %0d, got %0d", want.summary_valid,
                 out_data.summary_valid);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: end the run if the block hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("tb_rsi_signal_trade_tracker: done, errors");
      $finish;
    end
  end

  // Drain everything outstanding, then let the sequencer settle.
  task automatic wait_drained();
    while (price_queue.size() > 0 || in_valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  // Write one register; also update the predictor's copy.
  task automatic write_reg(logic [1:0] idx, logic [16:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_UPPER:  upper_q = val[6:0];
      REG_LOWER:  lower_q = val[6:0];
      REG_MOVE:   move_q = val[15:0];
      REG_PROFIT: profit_q = longint'($signed(val));
      default: ;
    endcase
  endtask

  task automatic push_price(logic [31:0] px, bit fin);
    in_item_t it;
    it.close_price = px;
    it.last = fin;
    price_queue.insert(price_queue.size(), it);
  endtask

  // One price series: a random walk with trending stretches, so RSI swings
  // across the levels and trades open and close. Most series are long.
  task automatic push_series(int len, int scale_kind);
    longint px, step;
    int trend;
    case (scale_kind)
      0: px = $urandom_range(32'h0010_0000, 32'h0001_0000);
      1: px = 64'hFFFF_0000 - $urandom_range(32'h0100_0000);
      2: px = $urandom_range(64, 1);
      default: px = {$urandom} | 1;
    endcase
    trend = 0;
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(5) == 0) trend = int'($urandom_range(2)) - 1;
      case ($urandom_range(9))
        0: step = longint'($signed($urandom)) >>> $urandom_range(16);
        1: step = 0;
        default: step = (px >> $urandom_range(9, 3)) * trend
                        + (longint'($urandom_range(2000)) - 1000) * (px >> 14) / 64;
      endcase
      px += step;
      if (px < 1) px = 1 + $urandom_range(3);
      if (px > 64'hFFFF_FFFF) px = 64'hFFFF_FFFF - $urandom_range(3);
      push_price(32'(px), i == len - 1);
    end
  endtask

  task automatic random_phase(int series, int idle, int stall);
    send_idle_pct = idle;
    stall_pct = stall;
    for (int s = 0; s < series; s++)
      push_series(($urandom_range(3) == 0) ? $urandom_range(16, 1)
                                           : $urandom_range(60, 17), $urandom_range(3));
    wait_drained();
  endtask

  initial begin
    wipe_series();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extremes of the price, a single-item series, a steady rise
    // (no losses, RSI 100), a steep fall, a position opened on the last item.
    write_reg(REG_UPPER, 17'd60);
    write_reg(REG_LOWER, 17'd40);
    write_reg(REG_MOVE, 17'd0);
    write_reg(REG_PROFIT, 17'h10000);
    push_price(32'd1, 1'b1);
    for (int i = 0; i < 15; i++) push_price(32'd1 + i, 1'b0);
    push_price(32'hFFFF_FFFF, 1'b1);
    wait_drained();
    for (int i = 0; i < 16; i++) push_price(32'hFFFF_FFFF - i * 32'h1000_0000, 1'b0);
    push_price(32'd1, 1'b0);
    push_price(32'h8000_0000, 1'b1);
    wait_drained();

    // Random phases with several register settings, extremes included.
    random_phase(6, 0, 0);
    write_reg(REG_UPPER, 17'd100);
    write_reg(REG_LOWER, 17'd0);
    write_reg(REG_MOVE, 17'hFFFF);
    write_reg(REG_PROFIT, 17'h0FFFF);
    random_phase(3, 63, 0);
    write_reg(REG_UPPER, 17'd127);
    write_reg(REG_LOWER, 17'd127);
    write_reg(REG_MOVE, 17'd0);
    write_reg(REG_PROFIT, 17'd0);
    random_phase(3, 0, 63);
    write_reg(REG_UPPER, 17'd55);
    write_reg(REG_LOWER, 17'd45);
    write_reg(REG_MOVE, 17'd300);
    write_reg(REG_PROFIT, 17'd328);
    random_phase(10, 30, 30);

    // Long receiver hold-off while the sender keeps offering: the block fills up.
    stall_pct = 0;
    send_idle_pct = 0;
    hold_off_cycles = 3000;
    push_series(40, 0);
    wait_drained();

    write_reg(REG_UPPER, 17'd60);
    write_reg(REG_LOWER, 17'd40);
    write_reg(REG_MOVE, 17'd3277);
    write_reg(REG_PROFIT, 17'h1FFB8);
    random_phase(20, 0, 0);
    random_phase(20, 30, 30);

    $display("covered %0d results, %0d closed trades, %0d series summaries",
             results_seen, trades_seen, summaries_seen);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("tb_rsi_signal_trade_tracker: done, clean");
    end else begin
      $display("tb_rsi_signal_trade_tracker: done, errors");
    end
    $finish;
  end

endmodule
